// ===== design/ucai_pkg.sv =====
// ----------------------------------------------------------------------------
// ucai_pkg
// Shared types and constants for the UTF-8 code point lookup block.
// ----------------------------------------------------------------------------
package ucai_pkg;

    localparam int POINT_W   = 21;
    localparam int STATUS_W  = 2;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 64;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_FOUND = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;

    // Register index, taken from paddr[3] (registers sit on 8-byte slots)
    localparam logic CFG_REG_TARGET = 1'b0;

    // Lead byte classification masks and patterns
    localparam logic [7:0] MASK_1B  = 8'h80;
    localparam logic [7:0] PAT_1B   = 8'h00;
    localparam logic [7:0] MASK_2B  = 8'hE0;
    localparam logic [7:0] PAT_2B   = 8'hC0;
    localparam logic [7:0] MASK_3B  = 8'hF0;
    localparam logic [7:0] PAT_3B   = 8'hE0;
    localparam logic [7:0] MASK_4B  = 8'hF8;
    localparam logic [7:0] PAT_4B   = 8'hF0;
    localparam logic [7:0] MASK_CONT = 8'hC0;
    localparam logic [7:0] PAT_CONT  = 8'h80;

    // Payload masks
    localparam logic [7:0] PAY_2B   = 8'h1F;
    localparam logic [7:0] PAY_3B   = 8'h0F;
    localparam logic [7:0] PAY_4B   = 8'h07;
    localparam logic [7:0] PAY_CONT = 8'h3F;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_string;
    } t_item;

    typedef struct packed {
        logic                valid;
        logic [POINT_W-1:0]  code_point;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

// ===== design/ucai_if.sv =====
// ----------------------------------------------------------------------------
// ucai_byte_if / ucai_point_if
// Valid/ready channels: string bytes in, looked-up code point out.
// ----------------------------------------------------------------------------
interface ucai_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_string;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_string, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input end_of_string, output ready);
endinterface

interface ucai_point_if;
    logic                               valid;
    logic                               ready;
    logic [ucai_pkg::POINT_W-1:0]       code_point;
    logic [ucai_pkg::STATUS_W-1:0]      status;

    modport source (output valid, output code_point, output status, input ready);
    modport sink   (input valid, input code_point, input status, output ready);
endinterface

// ===== design/ucai_cfg.sv =====
// ----------------------------------------------------------------------------
// ucai_cfg
// APB register file holding the signed target index.
// ----------------------------------------------------------------------------
module ucai_cfg #(
    parameter int INDEX_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ucai_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [ucai_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [ucai_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [INDEX_WIDTH:0]                o_target
);

    logic [INDEX_WIDTH:0] r_target;
    logic                 sel_target;

    // Low address bits are byte offsets inside the 8-byte slot
    assign sel_target = (paddr[3] == ucai_pkg::CFG_REG_TARGET);
    assign pready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (psel && penable && pwrite && sel_target) begin
            r_target <= pwdata[INDEX_WIDTH:0];
        end
    end

    // Read back sign-extended
    always_comb begin
        prdata = '0;
        if (sel_target) begin
            prdata = {{(ucai_pkg::CFG_DATA_W-INDEX_WIDTH-1){r_target[INDEX_WIDTH]}},
                      r_target};
        end
    end

    assign o_target = r_target;

endmodule

// ===== design/ucai_decode.sv =====
// ----------------------------------------------------------------------------
// ucai_decode
// Per-string UTF-8 decode state and the one-byte step that advances it.
// ----------------------------------------------------------------------------
module ucai_decode #(
    parameter int INDEX_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  ucai_pkg::t_item       i_item,
    input  logic [INDEX_WIDTH:0]  i_target,
    output ucai_pkg::t_result     o_result
);

    logic [1:0]                     r_bytes_left, n_bytes_left;
    logic [ucai_pkg::POINT_W-1:0]   r_partial,    n_partial;
    logic [INDEX_WIDTH:0]           r_points,     n_points;
    logic                           r_answered,   n_answered;
    logic                           done;
    logic [7:0]                     b;

    assign b = i_item.data_byte;

    // One step of the decoder
    always_comb begin
        n_bytes_left = r_bytes_left;
        n_partial    = r_partial;
        n_points     = r_points;
        n_answered   = r_answered;
        done         = 1'b0;
        o_result     = '0;
        o_result.status = ucai_pkg::ST_FOUND;
        if (i_step) begin
            // negative index: answer at once
            if (!n_answered && i_target[INDEX_WIDTH]) begin
                o_result.valid  = 1'b1;
                o_result.status = ucai_pkg::ST_INDEX;
                n_answered      = 1'b1;
            end
            if (!n_answered && i_item.byte_present) begin
                if (r_bytes_left == 2'd0) begin
                    priority if ((b & ucai_pkg::MASK_1B) == ucai_pkg::PAT_1B) begin
                        n_partial = {13'd0, b};
                        done      = 1'b1;
                    end else if ((b & ucai_pkg::MASK_2B) == ucai_pkg::PAT_2B) begin
                        n_partial    = {13'd0, b & ucai_pkg::PAY_2B};
                        n_bytes_left = 2'd1;
                    end else if ((b & ucai_pkg::MASK_3B) == ucai_pkg::PAT_3B) begin
                        n_partial    = {13'd0, b & ucai_pkg::PAY_3B};
                        n_bytes_left = 2'd2;
                    end else if ((b & ucai_pkg::MASK_4B) == ucai_pkg::PAT_4B) begin
                        n_partial    = {13'd0, b & ucai_pkg::PAY_4B};
                        n_bytes_left = 2'd3;
                    end else begin
                        o_result.valid  = 1'b1;
                        o_result.status = ucai_pkg::ST_BAD;
                        n_answered      = 1'b1;
                    end
                end else if ((b & ucai_pkg::MASK_CONT) != ucai_pkg::PAT_CONT) begin
                    o_result.valid  = 1'b1;
                    o_result.status = ucai_pkg::ST_BAD;
                    n_answered      = 1'b1;
                end else begin
                    n_partial    = {r_partial[ucai_pkg::POINT_W-7:0], b[5:0]};
                    n_bytes_left = r_bytes_left - 2'd1;
                    done         = (r_bytes_left == 2'd1);
                end
                // completed code point: match or count (count saturates)
                if (done) begin
                    if (r_points == i_target) begin
                        o_result.valid      = 1'b1;
                        o_result.status     = ucai_pkg::ST_FOUND;
                        o_result.code_point = n_partial;
                        n_answered          = 1'b1;
                    end else if (!r_points[INDEX_WIDTH]) begin
                        n_points = r_points + 1'b1;
                    end
                end
            end
            // end of string: late error if unanswered, then clear
            if (i_item.end_of_string) begin
                if (!n_answered) begin
                    o_result.valid  = 1'b1;
                    o_result.status = (n_bytes_left != 2'd0) ? ucai_pkg::ST_BAD
                                                             : ucai_pkg::ST_INDEX;
                end
                n_bytes_left = '0;
                n_partial    = '0;
                n_points     = '0;
                n_answered   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_partial    <= '0;
            r_points     <= '0;
            r_answered   <= 1'b0;
        end else begin
            r_bytes_left <= n_bytes_left;
            r_partial    <= n_partial;
            r_points     <= n_points;
            r_answered   <= n_answered;
        end
    end

    // State is fresh after the last item of a string
    a_clear_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.end_of_string |=>
            (r_points == '0) && (r_bytes_left == 2'd0) && !r_answered)
        else $error("decode state not cleared at end of string");

    // Count never passes its saturation value
    a_points_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_points[INDEX_WIDTH] && (|r_points[INDEX_WIDTH-1:0])))
        else $error("code point count past saturation");

    // Error results carry a zero code point
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && (o_result.status != ucai_pkg::ST_FOUND) |->
            (o_result.code_point == '0))
        else $error("error result with nonzero code point");

    // At most one result per string
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_answered && i_step && !i_item.end_of_string |-> !o_result.valid)
        else $error("second result for one string");

endmodule

// ===== design/utf8_codepoint_at_index_top.sv =====
// ----------------------------------------------------------------------------
// utf8_codepoint_at_index_top
// Returns the code point at a configured position of a UTF-8 byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   i_byte carries one string byte per transfer (byte_present = 0 for an
//   empty-string marker); end_of_string flags the last transfer of a string.
//   o_point gives at most one result per string: the code point at the
//   target index with status found, or status index error / malformed.
//   The target index is a signed register at APB address 0 (64-bit data).
//   Write it only while no string is in flight.
// Timing:
//   One byte per cycle sustained while no result waits on o_point. A byte is
//   captured in the input register, then the decode step loads the result
//   register, which drives o_point. The single decode state update per
//   cycle sets this rate.
// Reset (synchronous, active low) clears the target index, the decode state
//   and the valid flags of both pipeline registers.
// Stall: while a result waits on o_point, one more byte is still taken into
//   the input register; further bytes wait until the result is taken.
// ----------------------------------------------------------------------------
module utf8_codepoint_at_index_top #(
    parameter int INDEX_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ucai_byte_if.sink                           i_byte,
    ucai_point_if.source                        o_point,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ucai_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [ucai_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [ucai_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic [INDEX_WIDTH:0]   target;
    ucai_pkg::t_item        r_in;
    logic                   r_in_valid;
    ucai_pkg::t_result      result;
    ucai_pkg::t_result      r_out;
    logic                   advance;
    logic                   step;

    ucai_cfg #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_target (target)
    );

    // Pipeline moves when the result register is free or being drained
    assign advance      = !r_out.valid || o_point.ready;
    assign step         = r_in_valid && advance;
    assign i_byte.ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in.data_byte     <= i_byte.data_byte;
            r_in.byte_present  <= i_byte.byte_present;
            r_in.end_of_string <= i_byte.end_of_string;
        end
    end

    ucai_decode #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .i_target (target),
        .o_result (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (advance) begin
            r_out.valid <= result.valid;
            if (result.valid) begin
                r_out.code_point <= result.code_point;
                r_out.status     <= result.status;
            end
        end
    end

    assign o_point.valid      = r_out.valid;
    assign o_point.code_point = r_out.code_point;
    assign o_point.status     = r_out.status;

endmodule
